// ===== rtl/assert_macros.svh =====
// Assertion shorthands, clocked on the rising edge, off while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every edge.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Antecedent at an edge implies the consequent at that same edge.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/jdd_pkg.sv =====
package jdd_pkg;

  localparam int DIGIT_COUNT_DEF = 4;

  localparam int SAMPLE_W = 10;
  localparam int COOL_W   = 16;
  localparam int SCAN_W   = 8;
  localparam int VALUE_W  = 4;
  localparam int SEG_W    = 7;
  localparam int ENABLE_W = 4;
  localparam int CURPOS_W = 2;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_X_HIGH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_X_LOW      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Y_HIGH     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_LOW      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CURSOR_CD  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_VALUE_CD   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SCAN_PER   = 3'd6;

  // reset values
  localparam logic [SAMPLE_W-1:0] X_HIGH_RST    = 10'd600;
  localparam logic [SAMPLE_W-1:0] X_LOW_RST     = 10'd440;
  localparam logic [SAMPLE_W-1:0] Y_HIGH_RST    = 10'd600;
  localparam logic [SAMPLE_W-1:0] Y_LOW_RST     = 10'd430;
  localparam logic [COOL_W-1:0]   CURSOR_CD_RST = 16'd500;
  localparam logic [COOL_W-1:0]   VALUE_CD_RST  = 16'd250;
  localparam logic [SCAN_W-1:0]   SCAN_PER_RST  = 8'd2;

  localparam logic [VALUE_W-1:0] VALUE_MAX = 4'd9;

  typedef struct packed {
    logic [SAMPLE_W-1:0] x_high;
    logic [SAMPLE_W-1:0] x_low;
    logic [SAMPLE_W-1:0] y_high;
    logic [SAMPLE_W-1:0] y_low;
    logic [COOL_W-1:0]   cursor_cd;
    logic [COOL_W-1:0]   value_cd;
    logic [SCAN_W-1:0]   scan_period;
  } cfg_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] x_sample;
    logic [SAMPLE_W-1:0] y_sample;
  } item_t;

  typedef enum logic [1:0] {
    AXIS_REST,
    AXIS_HIGH,
    AXIS_LOW
  } axis_t;

  // High test wins when both thresholds are met.
  function automatic axis_t classify(input logic [SAMPLE_W-1:0] s,
                                     input logic [SAMPLE_W-1:0] hi,
                                     input logic [SAMPLE_W-1:0] lo);
    axis_t a;
    if (s > hi) begin
      a = AXIS_HIGH;
    end else if (s < lo) begin
      a = AXIS_LOW;
    end else begin
      a = AXIS_REST;
    end
    return a;
  endfunction

  // segments a..g in bits 0..6; codes above nine stay dark
  function automatic logic [SEG_W-1:0] seg_lookup(input logic [VALUE_W-1:0] v);
    logic [SEG_W-1:0] s;
    case (v)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h30;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h6F;
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/joystick_digit_editor_display.sv =====
// Joystick digit editor driving a multiplexed seven-segment display.
// Input stream: one transfer per display tick, carrying the raw X and Y
//   joystick samples. X moves the edit cursor across the digits, Y steps the
//   digit under the cursor through 0..9; each axis has its own cooldown.
// Output stream: exactly one transfer per input transfer, with the enable,
//   segment pattern and decimal point of the digit scanned on that tick plus
//   the cursor position and the value of the cursor digit after the update.
// Config port: cfg_we writes cfg_wdata into register cfg_index at the clock
//   edge (thresholds, cooldowns, scan period); write only while idle.
// Path: an input transfer is registered in the input register, then all edit
//   and scan work runs in one combinational pass into the result register;
//   the result shows valid once the output is free.
// Throughput: one transfer per cycle while out_tready holds. The input and
//   result registers act as a two-deep buffer, so a new item is taken while a
//   finished result still waits.
// Output stall: the result register holds; the input register fills and
//   then in_tready drops until out_tready returns. State only advances when
//   an item moves into the result register, so nothing is lost or repeated.
// Reset (rst_n low, synchronous): both stages empty, cursor, digits,
//   cooldown counters and scan position cleared, registers to defaults.
`include "assert_macros.svh"

module joystick_digit_editor_display
  import jdd_pkg::*;
#(
  parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // x_sample [9:0], y_sample [19:10], zero fill above
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // digit_enable_n [3:0], segment_bits [10:4], point_on [11],
  // cursor_position [13:12], selected_value [17:14], zero fill above
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int CW      = $clog2(DIGIT_COUNT);
  localparam int FIELD_W = ENABLE_W + SEG_W + 1 + CURPOS_W + VALUE_W;

  cfg_t  cfg;
  item_t s1_item;
  logic  s1_valid;
  logic  s1_adv;

  logic [DIGIT_COUNT-1:0][VALUE_W-1:0] digits_nxt;
  logic [CW-1:0]                       cursor_nxt;
  logic [VALUE_W-1:0]                  sel_value;
  logic [ENABLE_W-1:0]                 enable_n;
  logic [SEG_W-1:0]                    seg_bits;
  logic                                point_on;
  logic [OUT_TDATA_W-1:0]              result;

  // item leaves the input stage when the result register is free or draining
  assign s1_adv = s1_valid && (!out_tvalid || out_tready);

  jdd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  jdd_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .advance   (s1_adv),
    .s1_valid  (s1_valid),
    .s1_item   (s1_item)
  );

  jdd_edit #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_edit (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .advance    (s1_adv),
    .item       (s1_item),
    .digits_nxt (digits_nxt),
    .cursor_nxt (cursor_nxt),
    .sel_value  (sel_value)
  );

  // scan shows the digits after this tick's edit
  jdd_scan #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .advance    (s1_adv),
    .digits_nxt (digits_nxt),
    .cursor_nxt (cursor_nxt),
    .enable_n   (enable_n),
    .seg_bits   (seg_bits),
    .point_on   (point_on)
  );

  assign result = {{(OUT_TDATA_W - FIELD_W){1'b0}},
                   sel_value, CURPOS_W'(cursor_nxt), point_on, seg_bits, enable_n};

  jdd_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (s1_adv),
    .load_data  (result),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  `ASSERT_IMPLIES(a_stall_cause, clk, rst_n, !in_tready, s1_valid && out_tvalid && !out_tready, "input blocked without a full stall")
  `ASSERT_IMPLIES(a_out_source, clk, rst_n, $rose(out_tvalid), $past(s1_adv), "result appeared without an item")
  `ASSERT_IMPLIES(a_one_enable, clk, rst_n, out_tvalid && out_tdata[11], $countones(out_tdata[3:0]) >= 3, "point on a blanked digit")

endmodule

// ===== rtl/jdd_cfg.sv =====
module jdd_cfg
  import jdd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_X_HIGH:    cfg_nxt.x_high      = cfg_wdata[SAMPLE_W-1:0];
        REG_X_LOW:     cfg_nxt.x_low       = cfg_wdata[SAMPLE_W-1:0];
        REG_Y_HIGH:    cfg_nxt.y_high      = cfg_wdata[SAMPLE_W-1:0];
        REG_Y_LOW:     cfg_nxt.y_low       = cfg_wdata[SAMPLE_W-1:0];
        REG_CURSOR_CD: cfg_nxt.cursor_cd   = cfg_wdata[COOL_W-1:0];
        REG_VALUE_CD:  cfg_nxt.value_cd    = cfg_wdata[COOL_W-1:0];
        REG_SCAN_PER:  cfg_nxt.scan_period = cfg_wdata[SCAN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.x_high      <= X_HIGH_RST;
      cfg_r.x_low       <= X_LOW_RST;
      cfg_r.y_high      <= Y_HIGH_RST;
      cfg_r.y_low       <= Y_LOW_RST;
      cfg_r.cursor_cd   <= CURSOR_CD_RST;
      cfg_r.value_cd    <= VALUE_CD_RST;
      cfg_r.scan_period <= SCAN_PER_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/jdd_in_reg.sv =====
module jdd_in_reg
  import jdd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic                  advance,
  output logic                  s1_valid,
  output item_t                 s1_item
);

  logic  valid_r, valid_nxt;
  item_t item_r;
  logic  take;

  assign in_tready = !valid_r || advance;
  assign take      = in_tvalid && in_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r.x_sample <= in_tdata[SAMPLE_W-1:0];
      item_r.y_sample <= in_tdata[2*SAMPLE_W-1:SAMPLE_W];
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

// ===== rtl/jdd_edit.sv =====
`include "assert_macros.svh"

module jdd_edit
  import jdd_pkg::*;
#(
  parameter int DIGIT_COUNT = DIGIT_COUNT_DEF,
  localparam int CW = $clog2(DIGIT_COUNT)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  cfg_t                                cfg,
  input  logic                                advance,
  input  item_t                               item,
  output logic [DIGIT_COUNT-1:0][VALUE_W-1:0] digits_nxt,
  output logic [CW-1:0]                       cursor_nxt,
  output logic [VALUE_W-1:0]                  sel_value
);

  localparam logic [CW-1:0] CUR_LAST = CW'(DIGIT_COUNT - 1);

  logic [CW-1:0]                       cursor_r;
  logic [DIGIT_COUNT-1:0][VALUE_W-1:0] digits_r;
  logic [COOL_W-1:0]                   cur_el_r, cur_el_nxt;
  logic [COOL_W-1:0]                   val_el_r, val_el_nxt;

  axis_t             xd, yd;
  logic [COOL_W-1:0] cur_el_inc, val_el_inc;
  logic              fire_x, fire_y;

  assign xd = classify(item.x_sample, cfg.x_high, cfg.x_low);
  assign yd = classify(item.y_sample, cfg.y_high, cfg.y_low);

  // saturating tick counters
  assign cur_el_inc = (cur_el_r == '1) ? cur_el_r : cur_el_r + 1'b1;
  assign val_el_inc = (val_el_r == '1) ? val_el_r : val_el_r + 1'b1;

  assign fire_x = (xd != AXIS_REST) && (cur_el_inc >= cfg.cursor_cd);
  assign fire_y = (yd != AXIS_REST) && (val_el_inc >= cfg.value_cd);

  assign cur_el_nxt = fire_x ? '0 : cur_el_inc;
  assign val_el_nxt = fire_y ? '0 : val_el_inc;

  // X high steps left, X low steps right
  always_comb begin
    cursor_nxt = cursor_r;
    if (fire_x) begin
      if (xd == AXIS_LOW) begin
        cursor_nxt = (cursor_r == CUR_LAST) ? '0 : cursor_r + 1'b1;
      end else begin
        cursor_nxt = (cursor_r == '0) ? CUR_LAST : cursor_r - 1'b1;
      end
    end
  end

  // one lane per digit; only the lane under the new cursor changes
  for (genvar k = 0; k < DIGIT_COUNT; k++) begin : g_lane
    logic [VALUE_W-1:0] v, v_step;
    assign v = digits_r[k];
    always_comb begin
      if (yd == AXIS_HIGH) begin
        v_step = (v >= VALUE_MAX) ? '0 : v + 1'b1;
      end else begin
        v_step = (v == '0 || v > VALUE_MAX) ? VALUE_MAX : v - 1'b1;
      end
    end
    assign digits_nxt[k] = (fire_y && cursor_nxt == CW'(k)) ? v_step : v;
  end

  always_comb begin
    sel_value = '0;
    for (int k = 0; k < DIGIT_COUNT; k++) begin
      if (cursor_nxt == CW'(k)) begin
        sel_value = digits_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r <= '0;
      digits_r <= '0;
      cur_el_r <= '0;
      val_el_r <= '0;
    end else if (advance) begin
      cursor_r <= cursor_nxt;
      digits_r <= digits_nxt;
      cur_el_r <= cur_el_nxt;
      val_el_r <= val_el_nxt;
    end
  end

  `ASSERT_ALWAYS(a_cursor_range, clk, rst_n, cursor_r <= CUR_LAST, "cursor out of range")
  `ASSERT_IMPLIES(a_sel_digit, clk, rst_n, advance, sel_value <= VALUE_MAX, "digit above nine")

endmodule

// ===== rtl/jdd_scan.sv =====
module jdd_scan
  import jdd_pkg::*;
#(
  parameter int DIGIT_COUNT = DIGIT_COUNT_DEF,
  localparam int CW = $clog2(DIGIT_COUNT)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  cfg_t                                cfg,
  input  logic                                advance,
  input  logic [DIGIT_COUNT-1:0][VALUE_W-1:0] digits_nxt,
  input  logic [CW-1:0]                       cursor_nxt,
  output logic [ENABLE_W-1:0]                 enable_n,
  output logic [SEG_W-1:0]                    seg_bits,
  output logic                                point_on
);

  localparam logic [CW-1:0] SCAN_LAST = CW'(DIGIT_COUNT - 1);

  logic [CW-1:0]      scan_idx_r, scan_idx_nxt;
  logic [SCAN_W-1:0]  scan_ticks_r, scan_ticks_nxt;
  logic [SCAN_W-1:0]  ticks_inc;
  logic               wrap;
  logic [VALUE_W-1:0] shown;

  always_comb begin
    shown = '0;
    for (int k = 0; k < DIGIT_COUNT; k++) begin
      if (scan_idx_r == CW'(k)) begin
        shown = digits_nxt[k];
      end
    end
  end

  // digits four and up have no enable bit: the shift runs out to all ones
  assign enable_n = ~(ENABLE_W'(1) << scan_idx_r);
  assign seg_bits = seg_lookup(shown);
  assign point_on = (scan_idx_r == cursor_nxt);

  // period zero acts as one
  assign ticks_inc = scan_ticks_r + 1'b1;
  assign wrap      = (ticks_inc >= cfg.scan_period) || (ticks_inc == '0);

  assign scan_ticks_nxt = wrap ? '0 : ticks_inc;
  assign scan_idx_nxt   = !wrap ? scan_idx_r :
                          (scan_idx_r == SCAN_LAST) ? '0 : scan_idx_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r   <= '0;
      scan_ticks_r <= '0;
    end else if (advance) begin
      scan_idx_r   <= scan_idx_nxt;
      scan_ticks_r <= scan_ticks_nxt;
    end
  end

endmodule

// ===== rtl/jdd_out_reg.sv =====
module jdd_out_reg
  import jdd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  logic [OUT_TDATA_W-1:0] load_data,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  logic                   valid_r, valid_nxt;
  logic [OUT_TDATA_W-1:0] data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;

endmodule

// ===== tb/sv/joystick_digit_editor_display_tb.sv =====
module joystick_digit_editor_display_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import jdd_pkg::*;

  localparam int NDIGITS      = DIGIT_COUNT_DEF;
  localparam int QUIET_LIMIT  = 500;   // cycles without any transfer before giving up
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_ITEMS  = 66;
  localparam int REPORT_LIMIT = 100;   // keep the log short when the block is badly off

  // Index past the last register; writes there must be dropped.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  // Segment patterns for 0..9, segment a in bit 0.
  localparam logic [SEG_W-1:0] GLYPH [0:9] = '{
    7'h3F, 7'h30, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
  };

  // Result transfer as laid out on out_tdata, lowest field last.
  typedef struct packed {
    logic [OUT_TDATA_W-18-1:0] fill;
    logic [VALUE_W-1:0]        value;
    logic [CURPOS_W-1:0]       cursor;
    logic                      point;
    logic [SEG_W-1:0]          segs;
    logic [ENABLE_W-1:0]       enable_n;
  } frame_t;

  // Tracks the editor and scan state, predicts one display frame per tick
  // and checks the frames coming out in order.
  class frame_scoreboard;
    cfg_t                regs;
    int unsigned         cursor_idx;
    logic [VALUE_W-1:0]  digits [NDIGITS];
    logic [COOL_W-1:0]   cursor_elapsed;
    logic [COOL_W-1:0]   value_elapsed;
    int unsigned         scan_idx;
    logic [SCAN_W-1:0]   scan_ticks;
    frame_t              expected_frames [$];
    int                  errors;

    function new();
      regs.x_high      = X_HIGH_RST;
      regs.x_low       = X_LOW_RST;
      regs.y_high      = Y_HIGH_RST;
      regs.y_low       = Y_LOW_RST;
      regs.cursor_cd   = CURSOR_CD_RST;
      regs.value_cd    = VALUE_CD_RST;
      regs.scan_period = SCAN_PER_RST;
      cursor_idx       = 0;
      foreach (digits[i]) digits[i] = '0;
      cursor_elapsed   = '0;
      value_elapsed    = '0;
      scan_idx         = 0;
      scan_ticks       = '0;
      errors           = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_X_HIGH:    regs.x_high      = data[SAMPLE_W-1:0];
        REG_X_LOW:     regs.x_low       = data[SAMPLE_W-1:0];
        REG_Y_HIGH:    regs.y_high      = data[SAMPLE_W-1:0];
        REG_Y_LOW:     regs.y_low       = data[SAMPLE_W-1:0];
        REG_CURSOR_CD: regs.cursor_cd   = data[COOL_W-1:0];
        REG_VALUE_CD:  regs.value_cd    = data[COOL_W-1:0];
        REG_SCAN_PER:  regs.scan_period = data[SCAN_W-1:0];
        default: ;
      endcase
    endfunction

    // high test first, so it wins when both thresholds are met
    function axis_t sense(logic [SAMPLE_W-1:0] s, logic [SAMPLE_W-1:0] hi,
                          logic [SAMPLE_W-1:0] lo);
      if (s > hi) return AXIS_HIGH;
      if (s < lo) return AXIS_LOW;
      return AXIS_REST;
    endfunction

    function int pending();
      return expected_frames.size();
    endfunction

    // One accepted tick: advance the editor and scan, queue the frame.
    function void note_tick(logic [SAMPLE_W-1:0] x, logic [SAMPLE_W-1:0] y);
      axis_t  xa;
      axis_t  ya;
      frame_t f;
      xa = sense(x, regs.x_high, regs.x_low);
      ya = sense(y, regs.y_high, regs.y_low);

      if (cursor_elapsed != '1) cursor_elapsed++;
      if (value_elapsed != '1) value_elapsed++;

      // X low steps right, X high steps left
      if (xa != AXIS_REST && cursor_elapsed >= regs.cursor_cd) begin
        cursor_elapsed = '0;
        if (xa == AXIS_LOW) begin
          cursor_idx = (cursor_idx == NDIGITS - 1) ? 0 : cursor_idx + 1;
        end else begin
          cursor_idx = (cursor_idx == 0) ? NDIGITS - 1 : cursor_idx - 1;
        end
      end

      // Y acts on the digit under the already-moved cursor
      if (ya != AXIS_REST && value_elapsed >= regs.value_cd) begin
        value_elapsed = '0;
        if (ya == AXIS_HIGH) begin
          digits[cursor_idx] = (digits[cursor_idx] >= VALUE_MAX) ? '0
                                                                : digits[cursor_idx] + 1'b1;
        end else begin
          digits[cursor_idx] = (digits[cursor_idx] == '0) ? VALUE_MAX
                                                          : digits[cursor_idx] - 1'b1;
        end
      end

      f = '0;
      f.enable_n = '1;
      if (scan_idx < ENABLE_W) f.enable_n[scan_idx] = 1'b0;
      f.segs   = GLYPH[digits[scan_idx]];
      f.point  = (scan_idx == cursor_idx);
      f.cursor = cursor_idx[CURPOS_W-1:0];
      f.value  = digits[cursor_idx];
      expected_frames.push_back(f);

      // a zero period behaves like one
      scan_ticks = scan_ticks + 1'b1;
      if (scan_ticks >= regs.scan_period || scan_ticks == '0) begin
        scan_ticks = '0;
        scan_idx   = (scan_idx == NDIGITS - 1) ? 0 : scan_idx + 1;
      end
    endfunction

    task report(string what, int unsigned got, int unsigned want);
      errors++;
      if (errors <= REPORT_LIMIT)
        $display("%0t ns: %s mismatch, got 0x%0h expected 0x%0h", $time, what, got, want);
    endtask

    task check_frame(logic [OUT_TDATA_W-1:0] d);
      frame_t got;
      frame_t want;
      got = frame_t'(d);
      if (expected_frames.size() == 0) begin
        report("frame with nothing pending", d, 0);
        return;
      end
      want = expected_frames.pop_front();
      if (got.enable_n !== want.enable_n) report("digit_enable_n", got.enable_n, want.enable_n);
      if (got.segs !== want.segs)         report("segment_bits", got.segs, want.segs);
      if (got.point !== want.point)       report("point_on", got.point, want.point);
      if (got.cursor !== want.cursor)     report("cursor_position", got.cursor, want.cursor);
      if (got.value !== want.value)       report("selected_value", got.value, want.value);
      if (got.fill !== want.fill)         report("tdata fill", got.fill, want.fill);
    endtask
  endclass

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;   // x_sample [9:0], y_sample [19:10], zeros above
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;        // enable_n, segs, point, cursor, value from bit 0
  logic                   cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata  = '0;

  frame_scoreboard sb = new();
  bit              idle_on = 1'b1;   // random gaps/stalls on both sides when set
  int              quiet_cycles = 0;

  joystick_digit_editor_display #(.DIGIT_COUNT(NDIGITS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Result side: check each output transfer; count cycles with no transfer
  // at all for the watchdog.
  always @(posedge clk) begin
    if (rst_n && out_tvalid === 1'b1 && out_tready === 1'b1) begin
      sb.check_frame(out_tdata);
    end
    if ((in_tvalid && in_tready === 1'b1) || (out_tvalid === 1'b1 && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  // Receiver: random stall before taking each frame.
  initial begin : frame_sink
    int unsigned stall;
    forever begin
      stall = idle_on ? $urandom_range(0, 4) : 0;
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
    end
  end

  // One tick transfer. in_tvalid stays high across back-to-back ticks; the
  // prediction is made right at the accepting edge.
  task automatic send_tick(input logic [SAMPLE_W-1:0] x, input logic [SAMPLE_W-1:0] y);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TDATA_W'({y, x});
    do @(posedge clk); while (in_tready !== 1'b1);
    sb.note_tick(x, y);
  endtask

  // Hold the sender until every frame owed has come out.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  // Full register set, back to back; sometimes a stray write to the
  // unused index, which must change nothing.
  task automatic load_config(input logic [CFG_DATA_W-1:0] xh, input logic [CFG_DATA_W-1:0] xl,
                             input logic [CFG_DATA_W-1:0] yh, input logic [CFG_DATA_W-1:0] yl,
                             input logic [CFG_DATA_W-1:0] ccd, input logic [CFG_DATA_W-1:0] vcd,
                             input logic [CFG_DATA_W-1:0] sp);
    write_reg(REG_X_HIGH, xh);
    write_reg(REG_X_LOW, xl);
    write_reg(REG_Y_HIGH, yh);
    write_reg(REG_Y_LOW, yl);
    write_reg(REG_CURSOR_CD, ccd);
    write_reg(REG_VALUE_CD, vcd);
    write_reg(REG_SCAN_PER, sp);
    if ($urandom_range(0, 1)) write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  // Samples at or next to a threshold in four picks of ten, inside the rest
  // band or anywhere in range in three each.
  function automatic logic [SAMPLE_W-1:0] pick_sample(input logic [SAMPLE_W-1:0] hi,
                                                      input logic [SAMPLE_W-1:0] lo);
    logic [SAMPLE_W-1:0] a;
    logic [SAMPLE_W-1:0] b;
    logic [SAMPLE_W-1:0] s;
    a = (hi < lo) ? hi : lo;
    b = (hi < lo) ? lo : hi;
    case ($urandom_range(0, 9))
      0, 1, 2: s = SAMPLE_W'($urandom);
      3:       s = hi + 1'b1;
      4:       s = hi;
      5:       s = lo - 1'b1;
      6:       s = lo;
      default: s = SAMPLE_W'($urandom_range(a, b));
    endcase
    return s;
  endfunction

  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset thresholds and cooldowns: extremes and threshold edges, nothing
    // may fire yet since the cooldowns have not run out.
    send_tick(10'd0, 10'd0);
    send_tick(10'd1023, 10'd1023);
    send_tick(10'd600, 10'd600);
    send_tick(10'd601, 10'd601);
    send_tick(10'd439, 10'd429);
    drain();

    // Zero cooldowns and a zero scan period: every active tick moves.
    load_config(600, 440, 600, 430, 0, 0, 0);
    send_tick(10'd0, 10'd512);      // step right
    send_tick(10'd1023, 10'd512);   // step left
    send_tick(10'd1023, 10'd512);   // left wraps to the last digit
    send_tick(10'd0, 10'd512);      // right wraps to digit 0
    send_tick(10'd512, 10'd0);      // decrement wraps 0 -> 9
    send_tick(10'd512, 10'd1023);   // increment wraps 9 -> 0
    send_tick(10'd512, 10'd1023);
    send_tick(10'd0, 10'd1023);     // move, then edit the new digit
    send_tick(10'd601, 10'd601);
    send_tick(10'd600, 10'd600);    // equal to high threshold: at rest
    send_tick(10'd440, 10'd430);    // equal to low threshold: at rest
    send_tick(10'd439, 10'd429);
    drain();

    // Crossed thresholds: mid samples meet both tests, high one wins.
    load_config(100, 900, 100, 900, 0, 0, 1);
    send_tick(10'd500, 10'd500);
    send_tick(10'd50, 10'd50);
    send_tick(10'd950, 10'd950);
    drain();

    for (int p = 0; p < RAND_PHASES; p++) begin
      idle_on = (p != 2 && p != 5);
      case (p)
        0: load_config(600, 440, 600, 430, $urandom_range(0, 6), $urandom_range(0, 6),
                       $urandom_range(1, 4));
        // raw 16-bit threshold writes; upper bits must be dropped
        1: load_config($urandom, $urandom, $urandom, $urandom, 0, 0, 1);
        // X never active, Y always active, cooldowns never run out
        2: load_config(1023, 0, 0, 1023, 16'hFFFF, 16'hFFFF, 255);
        // X always active with no cooldown, Y never active
        3: load_config(0, 1023, 1023, 0, 0, 0, 255);
        4: load_config($urandom_range(500, 700), $urandom_range(350, 500),
                       $urandom_range(500, 700), $urandom_range(350, 500),
                       $urandom_range(0, 20), $urandom_range(0, 20), $urandom_range(1, 8));
        5: load_config(600, 440, 600, 430, 1, 1, 0);
        6: load_config($urandom_range(0, 1023), $urandom_range(0, 1023),
                       $urandom_range(0, 1023), $urandom_range(0, 1023),
                       $urandom_range(0, 40), $urandom_range(0, 40), $urandom_range(1, 3));
        default: load_config(X_HIGH_RST, X_LOW_RST, Y_HIGH_RST, Y_LOW_RST,
                             CURSOR_CD_RST, VALUE_CD_RST, SCAN_PER_RST);
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_tick(pick_sample(sb.regs.x_high, sb.regs.x_low),
                  pick_sample(sb.regs.y_high, sb.regs.y_low));
      end
      drain();
    end

    // Let any stray frame show up before the verdict.
    repeat (4) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/jdd_pkg.sv
rtl/jdd_cfg.sv
rtl/jdd_in_reg.sv
rtl/jdd_edit.sv
rtl/jdd_scan.sv
rtl/jdd_out_reg.sv
rtl/joystick_digit_editor_display.sv
tb/sv/joystick_digit_editor_display_tb.sv
